[sv/strlu_pkg.sv]
`default_nettype none
package strlu_pkg;

	localparam int ByteW = 8;
	localparam int NibW  = 4;
	localparam int StatW = 3;

	localparam logic [ByteW-1:0] ChBackslash = 8'h5C;
	localparam logic [ByteW-1:0] ChLowerR    = 8'h72;
	localparam logic [ByteW-1:0] ChLowerN    = 8'h6E;
	localparam logic [ByteW-1:0] ChCr        = 8'h0D;
	localparam logic [ByteW-1:0] ChLf        = 8'h0A;
	localparam logic [ByteW-1:0] ChSquote    = 8'h27;
	localparam logic [ByteW-1:0] ChDquote    = 8'h22;

	localparam logic [StatW-1:0] StRun      = 3'd0;
	localparam logic [StatW-1:0] StClosed   = 3'd1;
	localparam logic [StatW-1:0] StBsEnd    = 3'd2;
	localparam logic [StatW-1:0] StHexShort = 3'd3;
	localparam logic [StatW-1:0] StHexBad   = 3'd4;
	localparam logic [StatW-1:0] StEscBad   = 3'd5;
	localparam logic [StatW-1:0] StNewline  = 3'd6;
	localparam logic [StatW-1:0] StUnterm   = 3'd7;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] in_byte;
		logic             end_of_input;
	} in_t;

	typedef struct packed {
		logic [ByteW-1:0] out_byte;
		logic             byte_valid;
		logic [StatW-1:0] status;
		logic             done_res;
	} out_t;

	typedef struct packed {
		phase_t           phase;
		logic [ByteW-1:0] delimiter;
		logic [NibW-1:0]  high_nibble;
	} dec_state_t;

	typedef struct packed {
		logic            ok;
		logic [NibW-1:0] value;
	} hex_t;

	function automatic hex_t hex_value(input logic [ByteW-1:0] c);
		hex_t r;
		r.ok = 1'b1;
		r.value = '0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.value = NibW'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.value = NibW'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.value = NibW'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[sv/strlu_decode.sv]
`default_nettype none
module strlu_decode (
	input  var strlu_pkg::dec_state_t cur,
	input  var strlu_pkg::in_t        item,
	output strlu_pkg::dec_state_t     nxt,
	output strlu_pkg::out_t           res,
	output logic                      has_res
);

	logic [strlu_pkg::ByteW-1:0] b;
	logic                        last;
	logic                        is_quote;
	strlu_pkg::hex_t             h;

	assign b        = item.in_byte;
	assign last     = item.end_of_input;
	assign is_quote = (b == strlu_pkg::ChSquote) || (b == strlu_pkg::ChDquote);
	assign h        = strlu_pkg::hex_value(b);

	// next state
	always_comb begin
		nxt = cur;
		case (cur.phase)
			strlu_pkg::PH_IDLE: begin
				nxt.delimiter = b;
				nxt.phase = last ? strlu_pkg::PH_IDLE : strlu_pkg::PH_BODY;
			end
			strlu_pkg::PH_BODY: begin
				if (b == strlu_pkg::ChBackslash) begin
					nxt.phase = last ? strlu_pkg::PH_IDLE : strlu_pkg::PH_ESC;
				end else if (b == strlu_pkg::ChLf || (is_quote && b == cur.delimiter)) begin
					nxt.phase = strlu_pkg::PH_IDLE;
				end else begin
					nxt.phase = last ? strlu_pkg::PH_IDLE : strlu_pkg::PH_BODY;
				end
			end
			strlu_pkg::PH_ESC: begin
				if (b == strlu_pkg::ChLowerR || b == strlu_pkg::ChLowerN) begin
					nxt.phase = last ? strlu_pkg::PH_IDLE : strlu_pkg::PH_BODY;
				end else if (h.ok && !last) begin
					nxt.phase = strlu_pkg::PH_HEX;
					nxt.high_nibble = h.value;
				end else begin
					nxt.phase = strlu_pkg::PH_IDLE;
				end
			end
			strlu_pkg::PH_HEX: begin
				nxt.phase = (h.ok && !last) ? strlu_pkg::PH_BODY : strlu_pkg::PH_IDLE;
			end
			default: begin
				nxt.phase = strlu_pkg::PH_IDLE;
			end
		endcase
	end

	// result
	always_comb begin
		res = '0;
		case (cur.phase)
			strlu_pkg::PH_IDLE: begin
				if (last) begin
					res.done_res = 1'b1;
					res.status = strlu_pkg::StUnterm;
				end
			end
			strlu_pkg::PH_BODY: begin
				if (b == strlu_pkg::ChBackslash) begin
					if (last) begin
						res.done_res = 1'b1;
						res.status = strlu_pkg::StBsEnd;
					end
				end else if (b == strlu_pkg::ChLf) begin
					res.done_res = 1'b1;
					res.status = strlu_pkg::StNewline;
				end else if (is_quote && b == cur.delimiter) begin
					res.done_res = 1'b1;
					res.status = strlu_pkg::StClosed;
				end else begin
					res.byte_valid = 1'b1;
					res.out_byte = b;
					if (last) begin
						res.done_res = 1'b1;
						res.status = strlu_pkg::StUnterm;
					end
				end
			end
			strlu_pkg::PH_ESC: begin
				if (b == strlu_pkg::ChLowerR || b == strlu_pkg::ChLowerN) begin
					res.byte_valid = 1'b1;
					res.out_byte = (b == strlu_pkg::ChLowerR) ? strlu_pkg::ChCr
						: strlu_pkg::ChLf;
					if (last) begin
						res.done_res = 1'b1;
						res.status = strlu_pkg::StUnterm;
					end
				end else if (h.ok) begin
					if (last) begin
						res.done_res = 1'b1;
						res.status = strlu_pkg::StHexShort;
					end
				end else begin
					res.done_res = 1'b1;
					res.status = strlu_pkg::StEscBad;
				end
			end
			strlu_pkg::PH_HEX: begin
				if (h.ok) begin
					res.byte_valid = 1'b1;
					res.out_byte = {cur.high_nibble, h.value};
					if (last) begin
						res.done_res = 1'b1;
						res.status = strlu_pkg::StUnterm;
					end
				end else begin
					res.done_res = 1'b1;
					res.status = strlu_pkg::StHexBad;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign has_res = res.byte_valid | res.done_res;

endmodule
`default_nettype wire

[sv/string_literal_unescaper_unit.sv]
// Decodes a quoted string literal one source byte per transaction. The first byte after
// idle is taken as the delimiter; a matching single or double quote closes the string,
// backslash escapes (\r, \n, two hex digits) are decoded, and errors end the string.
// A byte enters an input register and is decoded into the result register once that
// register is free or being taken, and a new byte is accepted every cycle while the
// result side keeps taking results. Bytes that produce no result (opening delimiter,
// escape prefix, first hex digit) are consumed without a result transaction.
`default_nettype none
module string_literal_unescaper_unit (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_ready,
	input  var strlu_pkg::in_t  in_data,
	output logic            out_valid,
	input  wire             out_ready,
	output strlu_pkg::out_t out_data
);

	logic                  valid_s1;
	strlu_pkg::in_t        item_s1;
	strlu_pkg::dec_state_t st_q;
	strlu_pkg::dec_state_t st_nxt;
	strlu_pkg::out_t       res;
	logic                  has_res;
	logic                  advance;

	assign advance  = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	strlu_decode u_decode (
		.cur     (st_q),
		.item    (item_s1),
		.nxt     (st_nxt),
		.res     (res),
		.has_res (has_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: strlu_pkg::PH_IDLE, delimiter: '0, high_nibble: '0};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= has_res;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_result_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.byte_valid || out_data.done_res))
		else $error("result without byte or end");

	a_status_only_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.done_res) |-> (out_data.status == strlu_pkg::StRun))
		else $error("status set while string in progress");

	a_idle_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.done_res) |=> (st_q.phase == strlu_pkg::PH_IDLE))
		else $error("not idle after string end");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("pending result lost");
`endif

endmodule
`default_nettype wire

[bench/tb_top.sv]
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 4000;
	localparam int HoldCycles = 500;
	localparam int DrainCycles = 10;

	typedef enum logic [1:0] {
		RX_FULL,
		RX_HALF,
		RX_SPARSE,
		RX_MOSTLY
	} rx_mode_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	strlu_pkg::in_t  in_data;
	logic out_valid;
	logic out_ready;
	strlu_pkg::out_t out_data;

	string_literal_unescaper_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// pending source bytes and decoded results still owed by the block
	strlu_pkg::in_t  src_bytes[$];
	strlu_pkg::out_t decoded_q[$];

	int n_queued;
	int n_accepted;
	int n_results;
	int n_fails;
	bit in_acc;

	// shadow of the decoder state
	strlu_pkg::phase_t cur_phase;
	logic [7:0] cur_delim;
	logic [3:0] cur_nib;

	int burst_left;
	int gap_left;
	int hold_left;
	bit hold_done;
	int rx_left;
	rx_mode_t rx_mode;
	int quiet_cycles;

	always #1 clk = ~clk;

	function automatic bit nibble_of(input logic [7:0] c, output logic [3:0] v);
		v = '0;
		if (c inside {[8'h30:8'h39]}) begin
			v = c[3:0];
			return 1'b1;
		end
		if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			v = c[3:0] + 4'd9;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic bit decode_byte(input strlu_pkg::in_t it, output strlu_pkg::out_t r);
		logic [3:0] nv;
		logic       hx;
		logic [7:0] b;
		logic       eoi;
		b = it.in_byte;
		eoi = it.end_of_input;
		r = '0;
		hx = nibble_of(b, nv);
		case (cur_phase)
			strlu_pkg::PH_IDLE: begin
				cur_delim = b;
				cur_phase = strlu_pkg::PH_BODY;
				if (eoi) begin
					r.done_res = 1'b1;
					r.status = strlu_pkg::StUnterm;
				end
			end
			strlu_pkg::PH_BODY: begin
				if (b == strlu_pkg::ChBackslash) begin
					if (eoi) begin
						r.done_res = 1'b1;
						r.status = strlu_pkg::StBsEnd;
					end else begin
						cur_phase = strlu_pkg::PH_ESC;
					end
				end else if (b == strlu_pkg::ChLf) begin
					r.done_res = 1'b1;
					r.status = strlu_pkg::StNewline;
				end else if ((b == strlu_pkg::ChSquote || b == strlu_pkg::ChDquote)
						&& b == cur_delim) begin
					r.done_res = 1'b1;
					r.status = strlu_pkg::StClosed;
				end else begin
					r.byte_valid = 1'b1;
					r.out_byte = b;
					if (eoi) begin
						r.done_res = 1'b1;
						r.status = strlu_pkg::StUnterm;
					end
				end
			end
			strlu_pkg::PH_ESC: begin
				if (b == strlu_pkg::ChLowerR || b == strlu_pkg::ChLowerN) begin
					r.byte_valid = 1'b1;
					r.out_byte = (b == strlu_pkg::ChLowerR) ? strlu_pkg::ChCr
						: strlu_pkg::ChLf;
					cur_phase = strlu_pkg::PH_BODY;
					if (eoi) begin
						r.done_res = 1'b1;
						r.status = strlu_pkg::StUnterm;
					end
				end else if (hx) begin
					if (eoi) begin
						r.done_res = 1'b1;
						r.status = strlu_pkg::StHexShort;
					end else begin
						cur_nib = nv;
						cur_phase = strlu_pkg::PH_HEX;
					end
				end else begin
					r.done_res = 1'b1;
					r.status = strlu_pkg::StEscBad;
				end
			end
			default: begin
				if (hx) begin
					r.byte_valid = 1'b1;
					r.out_byte = {cur_nib, nv};
					cur_phase = strlu_pkg::PH_BODY;
					if (eoi) begin
						r.done_res = 1'b1;
						r.status = strlu_pkg::StUnterm;
					end
				end else begin
					r.done_res = 1'b1;
					r.status = strlu_pkg::StHexBad;
				end
			end
		endcase
		if (r.done_res) cur_phase = strlu_pkg::PH_IDLE;
		return r.byte_valid || r.done_res;
	endfunction

	task automatic push_src(input logic [7:0] b, input logic eoi);
		strlu_pkg::in_t t;
		t.in_byte = b;
		t.end_of_input = eoi;
		src_bytes = {src_bytes, t};
		n_queued++;
	endtask

	function automatic logic [7:0] hex_char();
		int v;
		v = $urandom_range(0, 15);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic bit is_quote(input logic [7:0] c);
		return c == strlu_pkg::ChSquote || c == strlu_pkg::ChDquote;
	endfunction

	function automatic logic [7:0] plain_char(input logic [7:0] dl);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == strlu_pkg::ChBackslash || c == strlu_pkg::ChLf
			|| (is_quote(dl) && c == dl));
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char(input bit no_esc_letter);
		logic [7:0] c;
		logic [3:0] v;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (nibble_of(c, v) || (no_esc_letter
			&& (c == strlu_pkg::ChLowerR || c == strlu_pkg::ChLowerN)));
		return c;
	endfunction

	task automatic add_string();
		logic [7:0] dl;
		int n;
		int pick;
		pick = $urandom_range(0, 99);
		// noise: raw bytes with scattered end flags
		if (pick < 8) begin
			n = $urandom_range(1, 10);
			repeat (n) push_src(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			return;
		end
		if (pick < 50) dl = strlu_pkg::ChDquote;
		else if (pick < 88) dl = strlu_pkg::ChSquote;
		else dl = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 49) == 0) begin
			push_src(dl, 1'b1);
			return;
		end
		push_src(dl, 1'b0);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				push_src(plain_char(dl), 1'b0);
			end else if (pick < 80) begin
				push_src(strlu_pkg::ChBackslash, 1'b0);
				push_src($urandom_range(0, 1) ? strlu_pkg::ChLowerR
					: strlu_pkg::ChLowerN, 1'b0);
			end else begin
				push_src(strlu_pkg::ChBackslash, 1'b0);
				push_src(hex_char(), 1'b0);
				push_src(hex_char(), 1'b0);
			end
		end
		pick = $urandom_range(0, 99);
		if (is_quote(dl) && pick >= 25) begin
			push_src(dl, $urandom_range(0, 4) == 0);
			return;
		end
		case (pick % 6)
			0: begin
				push_src(strlu_pkg::ChBackslash, 1'b0);
				case ($urandom_range(0, 3))
					0: push_src(strlu_pkg::ChBackslash, 1'b0);
					1: push_src(dl, 1'b0);
					default: push_src(non_hex_char(1'b1), 1'b0);
				endcase
			end
			1: begin
				push_src(strlu_pkg::ChBackslash, 1'b0);
				push_src(hex_char(), 1'b0);
				push_src(non_hex_char(1'b0), 1'($urandom_range(0, 1)));
			end
			2: push_src(strlu_pkg::ChLf, 1'($urandom_range(0, 1)));
			3: push_src(strlu_pkg::ChBackslash, 1'b1);
			4: begin
				push_src(strlu_pkg::ChBackslash, 1'b0);
				push_src(hex_char(), 1'b1);
			end
			default: push_src(plain_char(dl), 1'b1);
		endcase
	endtask

	task automatic add_random(input int count);
		int start;
		start = n_queued;
		while (n_queued - start < count) add_string();
	endtask

	task automatic wait_drain();
		while (!(n_accepted == n_queued && decoded_q.size() == 0)) @(negedge clk);
	endtask

	// source side
	always @(negedge clk) begin
		logic nxt_valid;
		if (arst_n) begin
			nxt_valid = in_valid;
			if (!in_valid || in_acc) begin
				nxt_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (src_bytes.size() > 0) begin
					in_data <= src_bytes.pop_front();
					nxt_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= nxt_valid;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_results >= 200) begin
				hold_done = 1'b1;
				hold_left = HoldCycles;
			end
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(16, 96);
			end else begin
				rx_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_FULL:   out_ready <= 1'b1;
					RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// transaction monitor and scoreboard
	always @(posedge clk) begin
		strlu_pkg::out_t exp_r;
		if (arst_n) begin
			in_acc = in_valid && in_ready;
			if (in_acc) begin
				n_accepted++;
				if (decode_byte(in_data, exp_r)) decoded_q = {decoded_q, exp_r};
			end
			if (out_valid && out_ready) begin
				n_results++;
				if (decoded_q.size() == 0) begin
					$error("result transaction with none expected: %p", out_data);
					n_fails++;
				end else begin
					exp_r = decoded_q.pop_front();
					if (out_data.out_byte !== exp_r.out_byte) begin
						$error("out_byte: expected %0h, got %0h",
							exp_r.out_byte, out_data.out_byte);
						n_fails++;
					end
					if (out_data.byte_valid !== exp_r.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b",
							exp_r.byte_valid, out_data.byte_valid);
						n_fails++;
					end
					if (out_data.status !== exp_r.status) begin
						$error("status: expected %0d, got %0d",
							exp_r.status, out_data.status);
						n_fails++;
					end
					if (out_data.done_res !== exp_r.done_res) begin
						$error("done_res: expected %0b, got %0b",
							exp_r.done_res, out_data.done_res);
						n_fails++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= QuietLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cur_phase = strlu_pkg::PH_IDLE;
		cur_delim = '0;
		cur_nib = '0;

		// opener as the last byte
		push_src(strlu_pkg::ChDquote, 1'b1);
		// data, both letter escapes, hex escape, close on the last byte
		push_src(strlu_pkg::ChDquote, 1'b0);
		push_src(8'h00, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(strlu_pkg::ChLowerN, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(strlu_pkg::ChLowerR, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(8'h46, 1'b0);
		push_src(8'h66, 1'b0);
		push_src(strlu_pkg::ChDquote, 1'b1);
		// other quote passes, backslash at end
		push_src(strlu_pkg::ChSquote, 1'b0);
		push_src(strlu_pkg::ChDquote, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b1);
		// hex cut short
		push_src(strlu_pkg::ChDquote, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(8'h61, 1'b1);
		// bad second hex digit
		push_src(strlu_pkg::ChDquote, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(8'h37, 1'b0);
		push_src(8'h67, 1'b0);
		// escaped backslash is not allowed
		push_src(strlu_pkg::ChSquote, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		push_src(strlu_pkg::ChBackslash, 1'b0);
		// non-quote delimiter never closes
		push_src(8'hFF, 1'b0);
		push_src(8'hFF, 1'b1);
		// raw newline on the last byte
		push_src(strlu_pkg::ChSquote, 1'b0);
		push_src(strlu_pkg::ChLf, 1'b1);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		wait_drain();
		add_random(750);
		wait_drain();
		add_random(750);
		wait_drain();
		repeat (DrainCycles) @(negedge clk);

		if (n_fails == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
